### hdl/crf_pkg.sv
`default_nettype none

package crf_pkg;

	// record format
	localparam int unsigned MAX_PAYLOAD = 512;
	localparam int unsigned REM_W = $clog2(MAX_PAYLOAD + 1);
	localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
	localparam logic [31:0] RECORD_MAGIC = 32'h45584653;
	localparam logic [15:0] RECORD_VER = 16'h0001;
	localparam logic [2:0] HDR_LAST = 3'd7;
	localparam logic [2:0] CRC_LAST = 3'd4;

	// input item kinds
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_LEN   = 2'd1,
		ST_NO_RECORD = 2'd2
	} status_t;

	// one accepted input item held for the byte generator
	typedef struct packed {
		logic        valid;
		logic        kind;
		logic [15:0] payload_length;
		logic [7:0]  data_byte;
	} item_t;

	// bytewise reflected crc update
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// header byte at a given position, little-endian fields
	function automatic logic [7:0] hdr_byte(input logic [2:0] idx, input logic [15:0] len);
		logic [7:0] b;
		case (idx)
			3'd0: b = RECORD_MAGIC[7:0];
			3'd1: b = RECORD_MAGIC[15:8];
			3'd2: b = RECORD_MAGIC[23:16];
			3'd3: b = RECORD_MAGIC[31:24];
			3'd4: b = len[7:0];
			3'd5: b = len[15:8];
			3'd6: b = RECORD_VER[7:0];
			default: b = RECORD_VER[15:8];
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

### hdl/crf_in_stage.sv
`default_nettype none

module crf_in_stage (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic         kind,
	input  wire logic [15:0]  payload_length,
	input  wire logic [7:0]   data_byte,
	input  wire logic         take,
	output crf_pkg::item_t    item
);
	import crf_pkg::*;

	logic        valid_s1;
	logic        kind_s1;
	logic [15:0] len_s1;
	logic [7:0]  byte_s1;

	// hold off while the held item still has results to give
	assign in_stall = valid_s1 && !take;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			len_s1 <= payload_length;
			byte_s1 <= data_byte;
		end
	end

	assign item = '{valid: valid_s1, kind: kind_s1, payload_length: len_s1,
		data_byte: byte_s1};

endmodule

`default_nettype wire

### hdl/crf_frame_gen.sv
`default_nettype none

module crf_frame_gen (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire crf_pkg::item_t item,
	output logic              take,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [7:0]        out_byte,
	output logic              run_last,
	output logic              frame_end,
	output logic [1:0]        status
);
	import crf_pkg::*;

	// record state
	logic [31:0]      crc_q;
	logic [REM_W-1:0] rem_q;
	logic             open_q;
	logic [2:0]       idx_q;

	// output register
	logic             ovalid_q;
	logic [7:0]       obyte_q;
	logic             olast_q;
	logic             ofend_q;
	status_t          ostat_q;

	logic             out_ready;
	logic             fire;
	logic             done;
	logic [7:0]       res_byte;
	logic             res_fend;
	status_t          res_stat;
	logic [31:0]      crc_d;
	logic [REM_W-1:0] rem_d;
	logic             open_d;
	logic             bad_len;
	logic [REM_W-1:0] rem_dec;
	logic [1:0]       crc_sel;
	logic [7:0]       hdr_b;

	assign out_ready = !ovalid_q || !out_stall;
	assign fire = item.valid && out_ready;
	assign take = fire && done;

	assign bad_len = (item.payload_length == 16'd0) || (item.payload_length > MAX_LEN);
	assign rem_dec = rem_q - REM_W'(1);
	assign crc_sel = 2'(idx_q - 3'd1);
	assign hdr_b = hdr_byte(idx_q, item.payload_length);

	// expand the held item into its result bytes, one per transfer
	always_comb begin
		res_byte = 8'd0;
		res_fend = 1'b0;
		res_stat = ST_OK;
		done = 1'b1;
		crc_d = crc_q;
		rem_d = rem_q;
		open_d = open_q;
		if (item.kind == KIND_START) begin
			if (bad_len) begin
				res_stat = ST_BAD_LEN;
				crc_d = CRC_INIT;
				rem_d = '0;
				open_d = 1'b0;
			end else begin
				// header bytes, crc folded in as each goes out
				res_byte = hdr_b;
				crc_d = crc_byte((idx_q == 3'd0) ? CRC_INIT : crc_q, hdr_b);
				done = (idx_q == HDR_LAST);
				if (idx_q == 3'd0) begin
					open_d = 1'b0;
				end
				if (done) begin
					rem_d = item.payload_length[REM_W-1:0];
					open_d = 1'b1;
				end
			end
		end else if (idx_q != 3'd0) begin
			// crc trailer, least significant byte first
			res_byte = crc_q[8*crc_sel +: 8];
			done = (idx_q == CRC_LAST);
			if (done) begin
				res_fend = 1'b1;
				open_d = 1'b0;
				crc_d = CRC_INIT;
			end
		end else if (!open_q || rem_q == '0) begin
			res_stat = ST_NO_RECORD;
		end else begin
			res_byte = item.data_byte;
			crc_d = crc_byte(crc_q, item.data_byte);
			rem_d = rem_dec;
			done = (rem_dec != '0);
		end
	end

	// state and item position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			rem_q <= '0;
			open_q <= 1'b0;
			idx_q <= 3'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (fire) begin
				crc_q <= crc_d;
				rem_q <= rem_d;
				open_q <= open_d;
				idx_q <= done ? 3'd0 : idx_q + 3'd1;
			end
			if (out_ready) begin
				ovalid_q <= item.valid;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			obyte_q <= res_byte;
			olast_q <= done;
			ofend_q <= res_fend;
			ostat_q <= res_stat;
		end
	end

	assign out_valid = ovalid_q;
	assign out_byte = obyte_q;
	assign run_last = olast_q;
	assign frame_end = ofend_q;
	assign status = ostat_q;

endmodule

`default_nettype wire

### hdl/crc32_record_framer_top.sv
// crc32 record framer
// input channel: in_valid/in_stall with kind, payload_length and data_byte.
// a start item (kind 0) with a length of 1..512 gives the 8-byte header
// (magic, length, version); each data item (kind 1) gives its byte, and the
// final payload byte is followed by the 4 crc bytes, least significant first.
// a bad length or data with no open record gives one byte with a nonzero
// status; a new start drops any open record.
// output channel: out_valid/out_stall, one byte per transfer, with run_last
// on the last byte of an item and frame_end on the final crc byte.
// the first byte of an item goes from the input register through the output
// register. throughput: one output byte per cycle while out_stall is low, so
// a data item gives 1 byte, the closing data item 5, a good start 8; the byte
// generator emits one byte a cycle, if unstalled, from a single input register.
// an output stall holds the output register and the byte generator; the
// input register still takes an item while it is empty.
// reset clears the record state: crc all ones, no record open.
`default_nettype none

module crc32_record_framer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [15:0] payload_length,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             run_last,
	output logic             frame_end,
	output logic [1:0]       status
);
	import crf_pkg::*;

	item_t item;
	logic  take;

	crf_in_stage u_in (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.payload_length (payload_length),
		.data_byte      (data_byte),
		.take           (take),
		.item           (item)
	);

	crf_frame_gen u_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.take      (take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.frame_end (frame_end),
		.status    (status)
	);

`ifndef SYNTHESIS
	// the crc trailer always closes an item
	a_fend_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> run_last && status == ST_OK)
		else $error("frame end without run end");

	// error results are single zero bytes
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> run_last && !frame_end && out_byte == 8'd0)
		else $error("malformed error result");

	// input held off only while an item is waiting in the input register
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> item.valid && !take)
		else $error("input stalled with nothing held");

	// a held item produces a transfer out whenever the output frees up
	a_progress: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && !(out_valid && out_stall) |=> out_valid)
		else $error("held item produced no result");
`endif

endmodule

`default_nettype wire
